FILE: hdl/tpm_pkg.sv
// Shared types and constants for the timestamp pair matcher.
// Holds table sizes, field widths, operation and status codes, the controller
// state type and the command/status bundles between controller and datapath.
package tpm_pkg;

  // Table depth and stored timestamp width
  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 32;

  // Address and count widths follow the table depth
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the stream items
  localparam int KIND_W     = 2;
  localparam int STAMP_W    = 32;
  localparam int OFFSET_W   = 32;
  localparam int MAXGAP_W   = 31;
  localparam int STATUS_W   = 2;
  localparam int IDX_OUT_W  = 6;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;

  // Arithmetic widths: shifted mic time, gap, doubled gap, three times max gap
  localparam int WIDE_T  = (TIME_BITS > OFFSET_W) ? TIME_BITS : OFFSET_W;
  localparam int SH_W    = WIDE_T + 2;
  localparam int GAP_W   = SH_W + 1;
  localparam int CMP_W   = GAP_W + 1;
  localparam int LIM_W   = MAXGAP_W + 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_MIC_PUSH = 2'd0,
    KIND_REF_PUSH = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_MATCH    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FOUND = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIC_PUSH,
    S_REF_PUSH,
    S_CLEAR,
    S_M_CHECK,
    S_M_ROW,
    S_M_LOAD,
    S_M_SCAN,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic capture;     // latch the incoming item
    logic push_mic;    // append stamp to the mic table
    logic push_ref;    // append stamp to the ref table
    logic clear;       // empty both tables
    logic match_init;  // start a match at mic row zero
    logic row_rd;      // read the current mic entry
    logic row_load;    // form the shifted mic time
    logic scan;        // stream ref entries and compare
    logic next_row;    // advance to the next mic row
    logic set_none;    // report no match
    logic emit;        // move the result to the output register
  } tpm_cmd_t;

  typedef struct packed {
    logic mic_empty;
    logic ref_empty;
    logic hit;
    logic row_end;
    logic last_row;
  } tpm_stat_t;

endpackage

FILE: hdl/tpm_dp.sv
// Datapath of the timestamp pair matcher: both timestamp tables, the counts,
// the match walk pointers, gap arithmetic and the result register.
// Depends on tpm_pkg; driven by tpm_ctrl through tpm_cmd_t.
module tpm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tpm_pkg::tpm_cmd_t               cmd,
  output tpm_pkg::tpm_stat_t              stat,
  input  logic [tpm_pkg::STAMP_W-1:0]     in_stamp,
  input  logic [tpm_pkg::OFFSET_W-1:0]    in_offset,
  input  logic [tpm_pkg::MAXGAP_W-1:0]    in_max_gap,
  output tpm_pkg::status_t                res_status,
  output logic [tpm_pkg::IDX_OUT_W-1:0]   res_mic_idx,
  output logic [tpm_pkg::IDX_OUT_W-1:0]   res_ref_idx
);
  import tpm_pkg::*;

  logic [TIME_BITS-1:0] mic_mem [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] ref_mem [QUEUE_DEPTH];

  logic [CNT_W-1:0]           mic_cnt_r, mic_cnt_nxt;
  logic [CNT_W-1:0]           ref_cnt_r, ref_cnt_nxt;
  logic [STAMP_W-1:0]         stamp_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [MAXGAP_W-1:0]        max_gap_r;
  logic [LIM_W-1:0]           limit3_r;
  logic [CNT_W-1:0]           row_r;
  logic [CNT_W-1:0]           issue_r;
  logic [ADDR_W-1:0]          cmp_idx_r;
  logic                       cmp_vld_r;
  logic                       behind_r;
  logic [TIME_BITS-1:0]       mic_q_r;
  logic [TIME_BITS-1:0]       ref_q_r;
  logic signed [SH_W-1:0]     shifted_r;
  status_t                    res_status_r;
  logic [ADDR_W-1:0]          res_mic_r;
  logic [ADDR_W-1:0]          res_ref_r;

  logic [STAMP_W+TIME_BITS-1:0] stamp_ext;
  logic [TIME_BITS-1:0]         stamp_cut;
  logic                         mic_full;
  logic                         ref_full;
  logic                         issue_ok;
  logic signed [SH_W-1:0]       mic_s;
  logic signed [SH_W-1:0]       off_s;
  logic signed [GAP_W-1:0]      ref_s;
  logic signed [GAP_W-1:0]      gap;
  logic signed [CMP_W-1:0]      gap2;
  logic signed [CMP_W-1:0]      lim_s;
  logic                         gap_pos;
  logic                         gap_neg;
  logic                         hit_fwd;
  logic                         hit_back;
  logic [ADDR_W-1:0]            hit_ref;
  logic [ADDR_W+IDX_OUT_W-1:0]  mic_idx_ext;
  logic [ADDR_W+IDX_OUT_W-1:0]  ref_idx_ext;

  // Keep only the low TIME_BITS of the stamp, zero-extend if narrower
  assign stamp_ext = {{TIME_BITS{1'b0}}, stamp_r};
  assign stamp_cut = stamp_ext[TIME_BITS-1:0];

  assign mic_full = (mic_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign ref_full = (ref_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign issue_ok = (issue_r < ref_cnt_r);

  assign mic_s = signed'(SH_W'(mic_q_r));
  assign off_s = SH_W'(offset_r);
  assign ref_s = signed'(GAP_W'(ref_q_r));
  assign gap   = GAP_W'(shifted_r) - ref_s;
  assign gap2  = {gap, 1'b0};
  assign lim_s = signed'(CMP_W'(limit3_r));

  assign gap_pos  = (gap > 0);
  assign gap_neg  = gap[GAP_W-1];
  assign hit_fwd  = cmp_vld_r && gap_pos && (gap2 < lim_s);
  assign hit_back = cmp_vld_r && gap_neg && behind_r;
  assign hit_ref  = hit_back ? (cmp_idx_r - ADDR_W'(1)) : cmp_idx_r;

  assign stat.mic_empty = (mic_cnt_r == '0);
  assign stat.ref_empty = (ref_cnt_r == '0);
  assign stat.hit       = hit_fwd || hit_back;
  assign stat.row_end   = !cmp_vld_r && !issue_ok;
  assign stat.last_row  = ((row_r + CNT_W'(1)) == mic_cnt_r);

  always_comb begin
    mic_cnt_nxt = mic_cnt_r;
    ref_cnt_nxt = ref_cnt_r;
    if (cmd.clear) begin
      mic_cnt_nxt = '0;
      ref_cnt_nxt = '0;
    end else begin
      if (cmd.push_mic && !mic_full) begin
        mic_cnt_nxt = mic_cnt_r + CNT_W'(1);
      end
      if (cmd.push_ref && !ref_full) begin
        ref_cnt_nxt = ref_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mic_cnt_r <= '0;
      ref_cnt_r <= '0;
      cmp_vld_r <= 1'b0;
      behind_r  <= 1'b0;
    end else begin
      mic_cnt_r <= mic_cnt_nxt;
      ref_cnt_r <= ref_cnt_nxt;
      if (cmd.row_rd) begin
        cmp_vld_r <= 1'b0;
        behind_r  <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= issue_ok;
        if (cmp_vld_r && gap_pos) begin
          behind_r <= 1'b1;
        end
      end
    end
  end

  // Table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.push_mic && !mic_full) begin
      mic_mem[mic_cnt_r[ADDR_W-1:0]] <= stamp_cut;
    end
    if (cmd.row_rd) begin
      mic_q_r <= mic_mem[row_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_ref && !ref_full) begin
      ref_mem[ref_cnt_r[ADDR_W-1:0]] <= stamp_cut;
    end
    if (cmd.scan && issue_ok) begin
      ref_q_r <= ref_mem[issue_r[ADDR_W-1:0]];
    end
  end

  // Operand capture, walk pointers and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stamp_r   <= in_stamp;
      offset_r  <= signed'(in_offset);
      max_gap_r <= in_max_gap;
    end
    if (cmd.match_init) begin
      limit3_r <= {max_gap_r, 1'b0} + LIM_W'(max_gap_r);
      row_r    <= '0;
    end else if (cmd.next_row) begin
      row_r <= row_r + CNT_W'(1);
    end
    if (cmd.row_rd) begin
      issue_r <= '0;
    end else if (cmd.scan && issue_ok) begin
      issue_r   <= issue_r + CNT_W'(1);
      cmp_idx_r <= issue_r[ADDR_W-1:0];
    end
    if (cmd.row_load) begin
      shifted_r <= mic_s - off_s;
    end

    if (cmd.push_mic) begin
      res_status_r <= mic_full ? ST_FULL : ST_OK;
      res_mic_r    <= '0;
      res_ref_r    <= '0;
    end else if (cmd.push_ref) begin
      res_status_r <= ref_full ? ST_FULL : ST_OK;
      res_mic_r    <= '0;
      res_ref_r    <= '0;
    end else if (cmd.clear) begin
      res_status_r <= ST_OK;
      res_mic_r    <= '0;
      res_ref_r    <= '0;
    end else if (cmd.set_none) begin
      res_status_r <= ST_NONE;
      res_mic_r    <= '0;
      res_ref_r    <= '0;
    end else if (cmd.scan && stat.hit) begin
      res_status_r <= ST_FOUND;
      res_mic_r    <= row_r[ADDR_W-1:0];
      res_ref_r    <= hit_ref;
    end
  end

  // Reported indices keep their low six bits
  assign mic_idx_ext = {{IDX_OUT_W{1'b0}}, res_mic_r};
  assign ref_idx_ext = {{IDX_OUT_W{1'b0}}, res_ref_r};
  assign res_mic_idx = mic_idx_ext[IDX_OUT_W-1:0];
  assign res_ref_idx = ref_idx_ext[IDX_OUT_W-1:0];
  assign res_status  = res_status_r;

endmodule

FILE: hdl/tpm_ctrl.sv
// Controller of the timestamp pair matcher: sequences appends, clears and the
// row-by-row match walk, and hands each result to the output register.
// Depends on tpm_pkg; drives tpm_dp through tpm_cmd_t.
module tpm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tpm_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  input  logic                       out_free,
  input  tpm_pkg::tpm_stat_t         stat,
  output tpm_pkg::tpm_cmd_t          cmd
);
  import tpm_pkg::*;

  state_t state_r, state_nxt;
  kind_t  kind;

  assign kind = kind_t'(in_kind);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_MIC_PUSH: state_nxt = S_MIC_PUSH;
            KIND_REF_PUSH: state_nxt = S_REF_PUSH;
            KIND_CLEAR:    state_nxt = S_CLEAR;
            KIND_MATCH:    state_nxt = S_M_CHECK;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_MIC_PUSH, S_REF_PUSH, S_CLEAR: state_nxt = S_REPORT;
      S_M_CHECK: begin
        state_nxt = (stat.mic_empty || stat.ref_empty) ? S_REPORT : S_M_ROW;
      end
      S_M_ROW:  state_nxt = S_M_LOAD;
      S_M_LOAD: state_nxt = S_M_SCAN;
      S_M_SCAN: begin
        if (stat.hit) begin
          state_nxt = S_REPORT;
        end else if (stat.row_end) begin
          state_nxt = stat.last_row ? S_REPORT : S_M_ROW;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MIC_PUSH: cmd.push_mic = 1'b1;
      S_REF_PUSH: cmd.push_ref = 1'b1;
      S_CLEAR:    cmd.clear    = 1'b1;
      S_M_CHECK: begin
        cmd.match_init = 1'b1;
        cmd.set_none   = stat.mic_empty || stat.ref_empty;
      end
      S_M_ROW:  cmd.row_rd   = 1'b1;
      S_M_LOAD: cmd.row_load = 1'b1;
      S_M_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.next_row = !stat.hit && stat.row_end && !stat.last_row;
        cmd.set_none = !stat.hit && stat.row_end && stat.last_row;
      end
      S_REPORT: cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/timestamp_pair_matcher.sv
// Top level of the timestamp pair matcher: stream ports, output register,
// and the controller and datapath instances.
// Depends on tpm_pkg, tpm_ctrl and tpm_dp.
//
// Each input transfer appends a mic or reference timestamp, clears both
// tables, or runs a match, and yields exactly one result transfer. A match
// walks mic entries in order and streams the reference table past each one
// through a single registered read port, one reference entry per cycle; the
// first matching pair ends the walk early. One item is worked on at a time:
// the input is ready again once the result sits in the output register, and
// that register holds it until the downstream side takes it. Both tables
// come out of reset empty; stored entries need no clearing pass.
module timestamp_pair_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] stamp, [63:32] delay_offset, [94:64] max_gap, [95] zero
  input  logic [tpm_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [tpm_pkg::KIND_W-1:0]       in_tuser,
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] mic_index, [11:6] ref_index, [15:12] zero
  output logic [tpm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [tpm_pkg::STATUS_W-1:0]     out_tuser
);
  import tpm_pkg::*;

  tpm_cmd_t                cmd;
  tpm_stat_t               stat;
  status_t                 res_status;
  logic [IDX_OUT_W-1:0]    res_mic_idx;
  logic [IDX_OUT_W-1:0]    res_ref_idx;
  logic                    out_free;

  logic                    out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic [IDX_OUT_W-1:0]    out_mic_r;
  logic [IDX_OUT_W-1:0]    out_ref_r;

  // The output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || out_tready;

  tpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Unpack the input payload; the top pad bit carries nothing
  tpm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_stamp    (in_tdata[STAMP_W-1:0]),
    .in_offset   (in_tdata[STAMP_W+OFFSET_W-1:STAMP_W]),
    .in_max_gap  (in_tdata[STAMP_W+OFFSET_W+MAXGAP_W-1:STAMP_W+OFFSET_W]),
    .res_status  (res_status),
    .res_mic_idx (res_mic_idx),
    .res_ref_idx (res_ref_idx)
  );

  // Output register: load on emit, drop valid once the transfer completes
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold the payload until the next emit
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status;
      out_mic_r    <= res_mic_idx;
      out_ref_r    <= res_ref_idx;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * IDX_OUT_W){1'b0}}, out_ref_r, out_mic_r};

endmodule

FILE: tb/sv/timestamp_pair_matcher_test.sv
// Testbench for timestamp_pair_matcher: directed and random stream traffic
// checked against a behavioral predictor of the two timestamp tables.
// Depends on tpm_pkg and the timestamp_pair_matcher RTL.
`timescale 1ns / 1ps

module timestamp_pair_matcher_test;
  import tpm_pkg::*;

  // Idle cycles with no transfer on either side before the run is declared
  // hung. The limit covers a full-table match walk without a hit together
  // with the receiver hold-off.
  localparam int IDLE_LIMIT   = 30000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 16;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct {
    status_t    status;
    logic [5:0] mic_idx;
    logic [5:0] ref_idx;
  } match_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] stamp, [63:32] delay_offset, [94:64] max_gap
  logic [KIND_W-1:0]     in_tuser;   // [1:0] kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [5:0] mic_index, [11:6] ref_index
  logic [STATUS_W-1:0]   out_tuser;  // [1:0] status

  timestamp_pair_matcher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor state: our own copy of both tables and their fill counts
  logic [TIME_BITS-1:0] mic_stamps [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] ref_stamps [QUEUE_DEPTH];
  int                   mic_fill;
  int                   ref_fill;

  // Results predicted for accepted inputs, oldest first
  match_result_t pending_results [$];
  match_result_t want;
  int            mismatches;
  int            items_sent;
  int            idle_cycles;

  // Sender pacing
  int burst_left;
  bit steady;

  // Receiver pacing
  rx_mode_t rx_mode;
  int       rx_phase_left;
  int       rx_tick;
  int       hold_left;
  bit       hold_kick;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one item to the predicted tables and return the result it yields.
  // Gap math runs in 64 bits, so neither the gap nor its doubling can wrap.
  function automatic match_result_t apply_item(kind_t k, logic [31:0] stamp,
                                               logic signed [31:0] delay,
                                               logic [30:0] max_gap);
    match_result_t r;
    longint        shifted;
    longint        gap;
    longint        limit3;
    bit            behind;
    bit            found;
    int            i;
    int            j;
    r.status  = ST_OK;
    r.mic_idx = '0;
    r.ref_idx = '0;
    case (k)
      KIND_MIC_PUSH: begin
        if (mic_fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mic_stamps[mic_fill] = stamp;
          mic_fill++;
        end
      end
      KIND_REF_PUSH: begin
        if (ref_fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ref_stamps[ref_fill] = stamp;
          ref_fill++;
        end
      end
      KIND_CLEAR: begin
        mic_fill = 0;
        ref_fill = 0;
      end
      default: begin
        found  = 1'b0;
        limit3 = longint'(max_gap) * 3;
        for (i = 0; i < mic_fill && !found; i++) begin
          behind  = 1'b0;
          shifted = longint'(mic_stamps[i]) - longint'(delay);
          for (j = 0; j < ref_fill && !found; j++) begin
            gap = shifted - longint'(ref_stamps[j]);
            if (gap < 0) begin
              // mic entry fell between two refs: take the earlier one
              if (behind) begin
                found     = 1'b1;
                r.mic_idx = i[5:0];
                r.ref_idx = 6'(j - 1);
              end
            end else if (gap > 0) begin
              behind = 1'b1;
              if (gap * 2 < limit3) begin
                found     = 1'b1;
                r.mic_idx = i[5:0];
                r.ref_idx = j[5:0];
              end
            end
          end
        end
        r.status = found ? ST_FOUND : ST_NONE;
      end
    endcase
    return r;
  endfunction

  // Offer one item and hold it until the block takes it. Between bursts,
  // drop valid for a random gap unless the sender is told to stay steady.
  task automatic push_item(input kind_t k, input logic [31:0] stamp,
                           input logic [31:0] delay, input logic [30:0] max_gap);
    if (!steady && burst_left == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {1'b0, max_gap, delay, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_item(k, stamp, delay, max_gap));
    items_sent++;
  endtask

  // Receiver: random phases of always-ready, coin-flip and sparse ready,
  // overridden by a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_kick) begin
      hold_left = HOLD_CYCLES;
      hold_kick = 1'b0;
    end
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 2));
      rx_phase_left = $urandom_range(16, 96);
    end else begin
      rx_phase_left--;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no prediction pending: status %0d", out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[5:0] !== want.mic_idx) begin
          $error("mic_index: expected %0d, got %0d", want.mic_idx, out_tdata[5:0]);
          mismatches++;
        end
        if (out_tdata[11:6] !== want.ref_idx) begin
          $error("ref_index: expected %0d, got %0d", want.ref_idx, out_tdata[11:6]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a run in which nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Match and append on empty tables
  task automatic test_empty_tables();
    push_item(KIND_CLEAR, '0, '0, '0);
    push_item(KIND_MATCH, '0, '0, 31'd100);
    push_item(KIND_MIC_PUSH, 32'd5, '0, '0);
    push_item(KIND_MATCH, '0, '0, 31'd100);
    push_item(KIND_CLEAR, '0, '0, '0);
    push_item(KIND_REF_PUSH, 32'd5, '0, '0);
    push_item(KIND_MATCH, '0, '0, 31'd100);
  endtask

  // Gap rules: positive gap within and at the limit, negative after positive,
  // zero gap, and the extremes of stamp, offset and max_gap.
  task automatic test_gap_rules();
    push_item(KIND_CLEAR, '0, '0, '0);
    push_item(KIND_MIC_PUSH, 32'd1000, '0, '0);
    push_item(KIND_REF_PUSH, 32'd990, '0, '0);
    push_item(KIND_REF_PUSH, 32'd1005, '0, '0);
    // max_gap zero: only the straddle path can match
    push_item(KIND_MATCH, '0, 32'd0, 31'd0);
    // gap 10 against limit 1.5 * 7
    push_item(KIND_MATCH, '0, 32'd0, 31'd7);
    // gap 3 exactly at 1.5 * 2: not below the limit
    push_item(KIND_MATCH, '0, 32'd7, 31'd2);
    // zero gap first, then negative with nothing behind: no match
    push_item(KIND_MATCH, '0, 32'd10, 31'd1000);
    push_item(KIND_MATCH, '0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_item(KIND_MIC_PUSH, 32'hFFFF_FFFF, '0, '0);
    push_item(KIND_REF_PUSH, 32'h0000_0000, '0, '0);
    push_item(KIND_MATCH, '0, 32'h8000_0000, 31'h7FFF_FFFF);
    push_item(KIND_MATCH, '0, 32'h8000_0000, 31'd0);
  endtask

  // Fill both tables, overflow each, and match at the far corners
  task automatic test_table_full();
    int k;
    push_item(KIND_CLEAR, '0, '0, '0);
    for (k = 0; k < QUEUE_DEPTH; k++) push_item(KIND_MIC_PUSH, 32'(k * 1000), '0, '0);
    push_item(KIND_MIC_PUSH, $urandom, '0, '0);
    for (k = 0; k < QUEUE_DEPTH; k++) push_item(KIND_REF_PUSH, 32'(k * 1000 + 500), '0, '0);
    push_item(KIND_REF_PUSH, $urandom, '0, '0);
    // every pair behind with max_gap zero: full walk, no match
    push_item(KIND_MATCH, '0, -32'sd63600, 31'd0);
    push_item(KIND_MATCH, '0, 32'd62490, 31'd10);
    push_item(KIND_MATCH, '0, -32'sd63510, 31'd10);
    push_item(KIND_MATCH, '0, -32'sd62500, 31'd0);
    push_item(KIND_CLEAR, '0, '0, '0);
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int k;
    steady    = 1'b1;
    hold_kick = 1'b1;
    push_item(KIND_CLEAR, '0, '0, '0);
    for (k = 0; k < 3; k++) push_item(KIND_MIC_PUSH, 32'(5000 + k * 100), '0, '0);
    for (k = 0; k < 3; k++) push_item(KIND_REF_PUSH, 32'(4950 + k * 100), '0, '0);
    push_item(KIND_MATCH, '0, '0, 31'd40);
    steady = 1'b0;
  endtask

  // Random sessions of evenly spaced mic and ref stamps with jitter and lag,
  // followed by matches near the lag; mixed with fully random noise items.
  task automatic test_random_sessions();
    int          first;
    int          nm;
    int          nr;
    int          pm;
    int          pr;
    int          period;
    int          lag;
    int          n_match;
    logic [31:0] base;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        push_item(kind_t'($urandom_range(0, 3)), $urandom, $urandom, 31'($urandom));
      end else begin
        // mostly short sessions, now and then a long one
        nm      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
        nr      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
        period  = $urandom_range(1, 5000);
        lag     = $urandom_range(0, 3 * period);
        base    = $urandom;
        n_match = $urandom_range(1, 3);
        pm      = 0;
        pr      = 0;
        if ($urandom_range(0, 9) != 0) push_item(KIND_CLEAR, '0, '0, '0);
        while (pm < nm || pr < nr) begin
          if (pr >= nr || (pm < nm && $urandom_range(0, 1))) begin
            push_item(KIND_MIC_PUSH,
                      base + 32'(pm * period + $urandom_range(0, period / 4)), '0, '0);
            pm++;
          end else begin
            push_item(KIND_REF_PUSH,
                      base - 32'(lag) + 32'(pr * period + $urandom_range(0, period / 4)),
                      '0, '0);
            pr++;
          end
        end
        repeat (n_match) begin
          push_item(KIND_MATCH, '0, 32'(lag + $urandom_range(0, 2 * period) - period),
                    31'($urandom_range(0, period)));
        end
      end
    end
  endtask

  initial begin
    // Known values on every input from time zero
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    mic_fill      = 0;
    ref_fill      = 0;
    mismatches    = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    steady        = 1'b0;
    rx_mode       = RX_OPEN;
    rx_phase_left = 0;
    rx_tick       = 0;
    hold_left     = 0;
    hold_kick     = 1'b0;

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_tables();
    test_gap_rules();
    test_backpressure();
    test_table_full();
    test_random_sessions();

    // Drop valid after the last transfer, then drain outstanding results
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
